FILE: hdl/tes_pkg.sv
// Package for the timed event scheduler: queue sizing, result codes,
// the stored entry layout and the ordering function.
// No dependencies.
`default_nettype none
package tes_pkg;
	localparam int QUEUE_DEPTH = 32;
	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [14:0] SLICE_LEN_RESET = 15'd20000;

	localparam logic [1:0] OP_SCHEDULE = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_ADVANCE = 2'd2;

	localparam logic [2:0] RK_FIRED = 3'd0;
	localparam logic [2:0] RK_SLICE = 3'd1;
	localparam logic [2:0] RK_SCHED = 3'd2;
	localparam logic [2:0] RK_REMOVE = 3'd3;
	localparam logic [2:0] RK_FULL = 3'd4;

	typedef struct packed {
		logic [63:0] due;
		logic [63:0] seq;
		logic [5:0] kind;
		logic [63:0] payload;
	} entry_t;

	// a before b: signed due time, then arrival order
	function automatic logic earlier(input entry_t a, input entry_t b);
		logic signed [63:0] ta;
		logic signed [63:0] tb;
		ta = a.due;
		tb = b.due;
		if (ta != tb)
			return ta < tb;
		return a.seq < b.seq;
	endfunction
endpackage
`default_nettype wire

FILE: hdl/tes_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module tes_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int AW = $clog2(DEPTH)
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [AW-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: hdl/timed_event_scheduler.sv
// Timed event scheduler top level: control sequencer around the entry RAM.
// Depends on tes_pkg and tes_ram.
//
// One word is taken at a time. Advance walks the entry RAM once per pop
// through its single read port, and the slice report follows the final scan;
// the queue is kept unsorted and the earliest entry is found by a scan. A
// stalled result word holds the sequencer for as long as it waits.
`default_nettype none
module timed_event_scheduler (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [14:0] cfg_wdata,
	input wire logic s_tvalid,
	output logic s_tready,
	// elapsed_in_slice[14:0], delay_cycles[46:15], event_kind[52:47],
	// event_payload[116:53]
	input wire logic [119:0] s_tdata,
	// operation[1:0]
	input wire logic [1:0] s_tuser,
	output logic m_tvalid,
	input wire logic m_tready,
	// fired_kind[5:0], fired_payload[69:6], lateness[101:70],
	// slice_remaining[116:102]
	output logic [119:0] m_tdata,
	// result_kind[2:0]
	output logic [2:0] m_tuser,
	output logic m_tlast
);
	localparam int IW = tes_pkg::IDX_W;
	localparam int CW = tes_pkg::CNT_W;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_SCHED = 4'd1;
	localparam logic [3:0] ST_RM_SCAN = 4'd2;
	localparam logic [3:0] ST_RM_DONE = 4'd3;
	localparam logic [3:0] ST_SCAN = 4'd4;
	localparam logic [3:0] ST_DECIDE = 4'd5;
	localparam logic [3:0] ST_FIRE = 4'd6;
	localparam logic [3:0] ST_MOVE = 4'd7;
	localparam logic [3:0] ST_REPORT = 4'd8;

	logic [3:0] state_q;
	logic [CW-1:0] count_q;
	logic [63:0] gtime_q;
	logic [63:0] nseq_q;
	logic [14:0] slice_q;
	logic [14:0] max_q;

	logic [14:0] elapsed_q;
	logic [31:0] delay_q;
	logic [5:0] kind_q;
	logic [63:0] payload_q;

	logic [CW-1:0] rd_idx_q;
	logic rv_s1;
	logic [IW-1:0] ridx_s1;
	logic [CW-1:0] wn_q;
	tes_pkg::entry_t best_q;
	logic [IW-1:0] best_idx_q;
	logic [14:0] len_q;
	logic [31:0] late_q;

	logic out_v_q;
	logic [119:0] out_d_q;
	logic [2:0] out_u_q;
	logic out_l_q;

	logic re, we;
	logic [IW-1:0] raddr, waddr;
	tes_pkg::entry_t wdata, rdata;

	logic out_free, out_load, accept, scan_issue, scan_end;
	logic [14:0] cap, rem, new_rem;
	logic [31:0] cpos;
	logic cut, full;
	logic [63:0] due_new, diff, gap;
	logic [CW-1:0] last_cnt;
	logic signed [63:0] bt_s, gt_s;

	assign out_free = !out_v_q || m_tready;
	assign out_load = out_free && (state_q == ST_SCHED || state_q == ST_RM_DONE
		|| state_q == ST_FIRE || state_q == ST_REPORT);
	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;
	assign m_tvalid = out_v_q;
	assign m_tdata = out_d_q;
	assign m_tuser = out_u_q;
	assign m_tlast = out_l_q;

	assign cap = (max_q == 15'd0) ? 15'd1 : max_q;
	assign rem = (slice_q > elapsed_q) ? slice_q - elapsed_q : 15'd0;
	assign cpos = delay_q[31] ? 32'd0 : delay_q;
	assign cut = {17'd0, rem} > cpos;
	assign new_rem = cut ? cpos[14:0] : rem;
	assign full = (count_q == CW'(tes_pkg::QUEUE_DEPTH));
	assign due_new = gtime_q + {49'd0, elapsed_q} + {{32{delay_q[31]}}, delay_q};
	assign diff = gtime_q - best_q.due;
	assign gap = best_q.due - gtime_q;
	assign bt_s = best_q.due;
	assign gt_s = gtime_q;
	assign last_cnt = count_q - CW'(1);

	assign scan_issue = ((state_q == ST_SCAN) || (state_q == ST_RM_SCAN))
		&& (rd_idx_q != count_q);
	assign scan_end = (rd_idx_q == count_q) && !rv_s1;

	always_comb begin
		re = scan_issue;
		raddr = rd_idx_q[IW-1:0];
		we = 1'b0;
		waddr = count_q[IW-1:0];
		wdata.due = due_new;
		wdata.seq = nseq_q;
		wdata.kind = kind_q;
		wdata.payload = payload_q;
		if (state_q == ST_FIRE) begin
			re = out_free;
			raddr = last_cnt[IW-1:0];
		end
		if (state_q == ST_SCHED && out_free && !full)
			we = 1'b1;
		if (state_q == ST_RM_SCAN && rv_s1 && rdata.kind != kind_q) begin
			we = 1'b1;
			waddr = wn_q[IW-1:0];
			wdata = rdata;
		end
		if (state_q == ST_MOVE) begin
			we = 1'b1;
			waddr = best_idx_q;
			wdata = rdata;
		end
	end

	tes_ram #(
		.WIDTH($bits(tes_pkg::entry_t)),
		.DEPTH(tes_pkg::QUEUE_DEPTH)
	) u_ram (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.re(re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			elapsed_q <= s_tdata[14:0];
			delay_q <= s_tdata[46:15];
			kind_q <= s_tdata[52:47];
			payload_q <= s_tdata[116:53];
		end
		if (rv_s1 && state_q == ST_SCAN
			&& (ridx_s1 == '0 || tes_pkg::earlier(rdata, best_q))) begin
			best_q <= rdata;
			best_idx_q <= ridx_s1;
		end
		if (state_q == ST_DECIDE)
			late_q <= (diff[63:32] != 32'd0) ? 32'hFFFF_FFFF : diff[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			gtime_q <= '0;
			nseq_q <= '0;
			slice_q <= tes_pkg::SLICE_LEN_RESET;
			max_q <= tes_pkg::SLICE_LEN_RESET;
			rd_idx_q <= '0;
			rv_s1 <= 1'b0;
			ridx_s1 <= '0;
			wn_q <= '0;
			len_q <= '0;
			out_v_q <= 1'b0;
			out_d_q <= '0;
			out_u_q <= '0;
			out_l_q <= 1'b0;
		end else begin
			if (cfg_we)
				max_q <= cfg_wdata;
			if (out_load)
				out_v_q <= 1'b1;
			else if (m_tready)
				out_v_q <= 1'b0;
			rv_s1 <= scan_issue;
			ridx_s1 <= rd_idx_q[IW-1:0];
			if (scan_issue)
				rd_idx_q <= rd_idx_q + CW'(1);
			unique case (state_q)
				ST_IDLE: begin
					rd_idx_q <= '0;
					wn_q <= '0;
					len_q <= cap;
					if (accept) begin
						unique case (s_tuser)
							tes_pkg::OP_SCHEDULE: state_q <= ST_SCHED;
							tes_pkg::OP_REMOVE: state_q <= ST_RM_SCAN;
							tes_pkg::OP_ADVANCE: begin
								gtime_q <= gtime_q + {49'd0, s_tdata[14:0]};
								state_q <= ST_SCAN;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_SCHED: begin
					if (out_free) begin
						out_l_q <= 1'b1;
						if (full) begin
							out_u_q <= tes_pkg::RK_FULL;
							out_d_q <= {3'd0, rem, 102'd0};
						end else begin
							out_u_q <= tes_pkg::RK_SCHED;
							out_d_q <= {3'd0, new_rem, 102'd0};
							count_q <= count_q + CW'(1);
							nseq_q <= nseq_q + 64'd1;
							if (cut)
								slice_q <= elapsed_q + cpos[14:0];
						end
						state_q <= ST_IDLE;
					end
				end
				ST_RM_SCAN: begin
					if (rv_s1 && rdata.kind != kind_q)
						wn_q <= wn_q + CW'(1);
					if (scan_end)
						state_q <= ST_RM_DONE;
				end
				ST_RM_DONE: begin
					if (out_free) begin
						count_q <= wn_q;
						out_l_q <= 1'b1;
						out_d_q <= '0;
						out_u_q <= tes_pkg::RK_REMOVE;
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (count_q == '0)
						state_q <= ST_REPORT;
					else if (scan_end)
						state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (bt_s <= gt_s) begin
						state_q <= ST_FIRE;
					end else begin
						if (gap < {49'd0, cap})
							len_q <= gap[14:0];
						state_q <= ST_REPORT;
					end
				end
				ST_FIRE: begin
					if (out_free) begin
						out_l_q <= 1'b0;
						out_u_q <= tes_pkg::RK_FIRED;
						out_d_q <= {3'd0, 15'd0, late_q, best_q.payload, best_q.kind};
						rd_idx_q <= '0;
						if (best_idx_q == last_cnt[IW-1:0]) begin
							count_q <= last_cnt;
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_MOVE;
						end
					end
				end
				ST_MOVE: begin
					count_q <= last_cnt;
					state_q <= ST_SCAN;
				end
				ST_REPORT: begin
					if (out_free) begin
						slice_q <= len_q;
						out_l_q <= 1'b1;
						out_u_q <= tes_pkg::RK_SLICE;
						out_d_q <= {3'd0, len_q, 102'd0};
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(tes_pkg::QUEUE_DEPTH))
		else $error("entry count beyond queue depth");

	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (s_tuser == tes_pkg::OP_SCHEDULE || s_tuser == tes_pkg::OP_REMOVE
			|| s_tuser == tes_pkg::OP_ADVANCE)) |=> !s_tready)
		else $error("second word taken while busy");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == ST_SCHED || state_q == ST_RM_SCAN || state_q == ST_MOVE))
		else $error("RAM write outside an update state");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE && state_q != ST_DECIDE && state_q != ST_SCAN
			&& state_q != ST_RM_SCAN && state_q != ST_MOVE && out_v_q && !m_tready)
		|=> $stable(out_d_q))
		else $error("result word overwritten while stalled");
endmodule
`default_nettype wire

FILE: test/timed_event_scheduler_test.sv
// Testbench for the timed event scheduler: drives schedule, remove and advance
// words, predicts every result word and compares it field by field.
// Depends on tes_pkg and timed_event_scheduler.
`default_nettype none
module timed_event_scheduler_test;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [2:0] rk;
		logic [5:0] kind;
		logic [63:0] payload;
		logic [31:0] late;
		logic [14:0] rem;
		logic last;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [14:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [119:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [119:0] m_tdata;
	logic [2:0] m_tuser;
	logic m_tlast;

	timed_event_scheduler dut (.*);

	always #6 clk = ~clk;

	// predictor state
	tes_pkg::entry_t queue_q[tes_pkg::QUEUE_DEPTH];
	int unsigned queue_count;
	logic [63:0] now_time;
	logic [63:0] seq_next;
	logic [14:0] slice_len;
	logic [14:0] slice_max;

	result_t results_due[$];
	int unsigned errors = 0;
	longint unsigned cycle = 0;
	bit gaps_on = 1'b1;
	int unsigned hold_asks = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_cnt = 0;

	function automatic logic [14:0] slice_left(logic [14:0] elapsed);
		return (slice_len > elapsed) ? slice_len - elapsed : 15'd0;
	endfunction

	function automatic bit due_before(tes_pkg::entry_t a, tes_pkg::entry_t b);
		if ($signed(a.due) != $signed(b.due))
			return $signed(a.due) < $signed(b.due);
		return a.seq < b.seq;
	endfunction

	function automatic void push_result(logic [2:0] rk, logic [5:0] kind, logic [63:0] pay,
			logic [31:0] late, logic [14:0] rem, logic last);
		result_t r;
		r = '{rk, kind, pay, late, rem, last};
		results_due.push_back(r);
	endfunction

	function automatic void predict_scheduler(logic [1:0] op, logic [14:0] elapsed,
			logic [31:0] delay, logic [5:0] kind, logic [63:0] pay);
		logic [63:0] d64;
		logic [63:0] late;
		logic [63:0] gap;
		logic [31:0] len;
		logic [31:0] c;
		int unsigned n;
		int unsigned best;
		d64 = {{32{delay[31]}}, delay};
		case (op)
			tes_pkg::OP_SCHEDULE: begin
				if (queue_count >= tes_pkg::QUEUE_DEPTH) begin
					push_result(tes_pkg::RK_FULL, '0, '0, '0, slice_left(elapsed), 1'b1);
				end else begin
					queue_q[queue_count] = '{now_time + {49'd0, elapsed} + d64, seq_next,
						kind, pay};
					seq_next++;
					queue_count++;
					c = delay[31] ? 32'd0 : delay;
					if ({17'd0, slice_left(elapsed)} > c)
						slice_len = elapsed + c[14:0];
					push_result(tes_pkg::RK_SCHED, '0, '0, '0, slice_left(elapsed), 1'b1);
				end
			end
			tes_pkg::OP_REMOVE: begin
				n = 0;
				for (int i = 0; i < queue_count; i++)
					if (queue_q[i].kind != kind)
						queue_q[n++] = queue_q[i];
				queue_count = n;
				push_result(tes_pkg::RK_REMOVE, '0, '0, '0, '0, 1'b1);
			end
			tes_pkg::OP_ADVANCE: begin
				len = (slice_max == 15'd0) ? 32'd1 : {17'd0, slice_max};
				now_time = now_time + {49'd0, elapsed};
				while (queue_count > 0) begin
					best = 0;
					for (int i = 1; i < queue_count; i++)
						if (due_before(queue_q[i], queue_q[best]))
							best = i;
					if ($signed(queue_q[best].due) > $signed(now_time)) begin
						gap = queue_q[best].due - now_time;
						if (gap < {32'd0, len})
							len = gap[31:0];
						break;
					end
					late = now_time - queue_q[best].due;
					if (late > 64'hFFFF_FFFF)
						late = 64'hFFFF_FFFF;
					push_result(tes_pkg::RK_FIRED, queue_q[best].kind, queue_q[best].payload,
						late[31:0], '0, 1'b0);
					queue_count--;
					queue_q[best] = queue_q[queue_count];
				end
				slice_len = len[14:0];
				push_result(tes_pkg::RK_SLICE, '0, '0, '0, len[14:0], 1'b1);
			end
			default: ;
		endcase
	endfunction

	task automatic send_word(logic [1:0] op, logic [14:0] elapsed, logic [31:0] delay,
			logic [5:0] kind, logic [63:0] pay);
		int unsigned gap;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 18);
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {3'b0, pay, kind, delay, elapsed};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_scheduler(op, elapsed, delay, kind, pay);
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_slice_max(logic [14:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		slice_max = value;
	endtask

	task automatic send_random_word();
		logic [31:0] delay;
		logic [5:0] kind;
		logic [14:0] elapsed;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		case ($urandom_range(0, 3))
			0: delay = $urandom;
			1: delay = -$urandom_range(0, 300);
			default: delay = $urandom_range(0, 3000);
		endcase
		kind = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 5));
		elapsed = ($urandom_range(0, 7) == 0) ? 15'($urandom) : 15'($urandom_range(0, 400));
		if (pick < 55)
			send_word(tes_pkg::OP_SCHEDULE, elapsed, delay, kind, {$urandom, $urandom});
		else if (pick < 65)
			send_word(tes_pkg::OP_REMOVE, elapsed, delay, kind, {$urandom, $urandom});
		else if (pick < 97)
			send_word(tes_pkg::OP_ADVANCE, elapsed, delay, kind, {$urandom, $urandom});
		else
			send_word(2'd3, elapsed, delay, kind, {$urandom, $urandom});
	endtask

	task automatic test_directed();
		send_word(tes_pkg::OP_SCHEDULE, 15'd0, 32'd100, 6'd0, 64'd0);
		send_word(tes_pkg::OP_SCHEDULE, 15'h7FFF, 32'h7FFF_FFFF, 6'h3F,
			64'hFFFF_FFFF_FFFF_FFFF);
		send_word(tes_pkg::OP_SCHEDULE, 15'd10, 32'h8000_0000, 6'd5, 64'h0123_4567_89AB_CDEF);
		send_word(tes_pkg::OP_SCHEDULE, 15'd10, -32'sd5, 6'd5, 64'hA5A5);
		send_word(tes_pkg::OP_SCHEDULE, 15'd0, 32'd100, 6'd7, 64'h77);
		send_word(2'd3, 15'd1, 32'd1, 6'd1, 64'd1);
		send_word(tes_pkg::OP_REMOVE, 15'd0, 32'd0, 6'd5, 64'd0);
		send_word(tes_pkg::OP_ADVANCE, 15'd200, 32'd0, 6'd0, 64'd0);
		send_word(tes_pkg::OP_ADVANCE, 15'h7FFF, 32'hFFFF_FFFF, 6'h3F, 64'd0);
		// fill the queue, then overflow it
		for (int i = 0; i < tes_pkg::QUEUE_DEPTH + 2; i++)
			send_word(tes_pkg::OP_SCHEDULE, 15'(i), 32'(i * 3), 6'(i), 64'(i));
		send_word(tes_pkg::OP_ADVANCE, 15'd50, 32'd0, 6'd0, 64'd0);
		send_word(tes_pkg::OP_ADVANCE, 15'd100, 32'd0, 6'd0, 64'd0);
	endtask

	task automatic test_slice_limits();
		write_slice_max(15'd0);
		send_word(tes_pkg::OP_ADVANCE, 15'd0, 32'd0, 6'd0, 64'd0);
		send_word(tes_pkg::OP_SCHEDULE, 15'd3, 32'd9, 6'd2, 64'd2);
		send_word(tes_pkg::OP_ADVANCE, 15'd20, 32'd0, 6'd0, 64'd0);
		write_slice_max(15'h7FFF);
		send_word(tes_pkg::OP_ADVANCE, 15'd0, 32'd0, 6'd0, 64'd0);
		write_slice_max(15'd1);
		send_word(tes_pkg::OP_ADVANCE, 15'd0, 32'd0, 6'd0, 64'd0);
	endtask

	task automatic test_random(int unsigned count, logic [14:0] max_len);
		write_slice_max(max_len);
		repeat (count) send_random_word();
	endtask

	task automatic test_backpressure();
		drain();
		hold_asks++;
		repeat (40) send_word(tes_pkg::OP_SCHEDULE, 15'd0, -32'sd1, 6'($urandom),
			{$urandom, $urandom});
		send_word(tes_pkg::OP_ADVANCE, 15'd0, 32'd0, 6'd0, 64'd0);
	endtask

	// result checker
	always @(posedge clk) begin
		result_t want;
		if (m_tvalid && m_tready) begin
			if (results_due.size() == 0) begin
				$error("result_kind exp none got %0d", m_tuser);
				errors++;
			end else begin
				want = results_due.pop_front();
				if (m_tuser != want.rk) begin
					$error("result_kind exp %0d got %0d", want.rk, m_tuser);
					errors++;
				end
				if (m_tdata[5:0] != want.kind) begin
					$error("fired_kind exp %0d got %0d", want.kind, m_tdata[5:0]);
					errors++;
				end
				if (m_tdata[69:6] != want.payload) begin
					$error("fired_payload exp %h got %h", want.payload, m_tdata[69:6]);
					errors++;
				end
				if (m_tdata[101:70] != want.late) begin
					$error("lateness exp %0d got %0d", want.late, m_tdata[101:70]);
					errors++;
				end
				if (m_tdata[116:102] != want.rem) begin
					$error("slice_remaining exp %0d got %0d", want.rem, m_tdata[116:102]);
					errors++;
				end
				if (m_tlast != want.last) begin
					$error("last exp %0d got %0d", want.last, m_tlast);
					errors++;
				end
			end
		end
	end

	// receiver: long hold-off when asked, otherwise random stalls while gaps are on, else always ready
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_seen != hold_asks) begin
			hold_seen <= hold_asks;
			hold_cnt <= 400;
			m_tready <= 1'b0;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
			m_tready <= 1'b0;
		end else if (gaps_on) begin
			m_tready <= ($urandom_range(0, 3) != 0);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > 2_000_000) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		queue_count = 0;
		now_time = '0;
		seq_next = '0;
		slice_len = tes_pkg::SLICE_LEN_RESET;
		slice_max = tes_pkg::SLICE_LEN_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_slice_limits();
		test_backpressure();
		test_random(40, 15'd500);
		test_random(40, 15'd20000);
		gaps_on = 1'b0;
		test_random(40, 15'd50);
		drain();
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
`default_nettype wire
